// ===== hdl/sle_pkg.sv =====
// Shared constants, codes and controller/datapath types of the sorted list engine.
package sle_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT_ABSENT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH        = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP           = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic {
    WR_MOVE,
    WR_VALUE
  } wr_sel_t;

  typedef enum logic [1:0] {
    VOUT_KEEP,
    VOUT_VALUE,
    VOUT_RDATA
  } vout_sel_t;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wr_sel_t             wr_sel;
    logic                idx_inc;
    logic                idx_dec;
    logic                idx_to_cnt;
    logic                set_pos;
    logic                set_found;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    vout_sel_t           vout_sel;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                cnt_clr;
    logic                out_load;
  } sle_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              at_end;
    logic              at_pos;
    logic              last;
    logic              gt;
    logic              eq;
    logic              out_stall;
  } sle_stat_t;

endpackage

// ===== hdl/sle_req_if.sv =====
// Request channel: operation and operand with valid/ready handshake.
interface sle_req_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== hdl/sle_rsp_if.sv =====
// Result channel: status, match flag, value, position and count with valid/ready.
interface sle_rsp_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     found;
  logic signed [DATA_W-1:0] value_out;
  logic [POS_W-1:0]         position;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output status, output found, output value_out,
                  output position, output count, input ready);
  modport sink   (input valid, input status, input found, input value_out,
                  input position, input count, output ready);
endinterface

// ===== hdl/sle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sle_ctrl.sv =====
// Controller: sequences scan, shift and result transfer for each request.
module sle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_cmd_t  cmd
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_MATCH,
    ACT_DELETE,
    ACT_FULL,
    ACT_MISS,
    ACT_POP
  } act_t;

  ctrl_state_t state_r, state_nxt;
  act_t        act;
  logic        act_go;
  logic        stop;
  logic        hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan ends at the first entry that settles the request, or at the list end.
  always_comb begin
    case (stat.mode)
      MODE_INSERT:                                   stop = stat.gt;
      MODE_INSERT_ABSENT, MODE_SEARCH, MODE_DELETE:  stop = stat.gt | stat.eq;
      default:                                       stop = 1'b1;
    endcase
    hit    = (state_r == S_SCAN_CMP) && stat.eq;
    act_go = ((state_r == S_SCAN_RD) && stat.at_end) ||
             ((state_r == S_SCAN_CMP) && stop);
    case (stat.mode)
      MODE_INSERT:        act = ACT_INSERT;
      MODE_INSERT_ABSENT: act = hit ? ACT_MATCH : (stat.full ? ACT_FULL : ACT_INSERT);
      MODE_SEARCH:        act = hit ? ACT_MATCH : ACT_MISS;
      MODE_DELETE:        act = hit ? ACT_DELETE : ACT_MISS;
      MODE_POP:           act = ACT_POP;
      default:            act = ACT_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_INSERT:                                  state_nxt = stat.full ? S_DONE : S_SCAN_RD;
          MODE_INSERT_ABSENT, MODE_SEARCH, MODE_DELETE: state_nxt = S_SCAN_RD;
          MODE_POP:                                     state_nxt = stat.empty ? S_DONE : S_SCAN_RD;
          default:                                      state_nxt = S_DONE;
        endcase
      end
      S_SCAN_RD, S_SCAN_CMP: begin
        if (act_go) begin
          case (act)
            ACT_INSERT:          state_nxt = S_UP_RD;
            ACT_DELETE, ACT_POP: state_nxt = S_DN_RD;
            default:             state_nxt = S_DONE;
          endcase
        end else begin
          state_nxt = (state_r == S_SCAN_RD) ? S_SCAN_CMP : S_SCAN_RD;
        end
      end
      S_UP_RD: state_nxt = stat.at_pos ? S_DONE : S_UP_WR;
      S_UP_WR: state_nxt = S_UP_RD;
      S_DN_RD: state_nxt = stat.last ? S_DONE : S_DN_WR;
      S_DN_WR: state_nxt = S_DN_RD;
      S_DONE: begin
        if (!stat.out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        if (stat.mode == MODE_INSERT && stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
        end else if (stat.mode == MODE_POP && stat.empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_EMPTY;
        end else if (stat.mode == MODE_CLEAR) begin
          cmd.cnt_clr = 1'b1;
        end
      end
      S_SCAN_RD, S_SCAN_CMP: begin
        if (act_go) begin
          case (act)
            ACT_INSERT: begin
              cmd.set_pos    = 1'b1;
              cmd.idx_to_cnt = 1'b1;
              cmd.vout_sel   = VOUT_VALUE;
            end
            ACT_MATCH, ACT_DELETE: begin
              cmd.set_pos   = 1'b1;
              cmd.set_found = 1'b1;
              cmd.vout_sel  = VOUT_VALUE;
            end
            ACT_FULL: begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end
            ACT_MISS: begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
            end
            ACT_POP: begin
              cmd.set_pos  = 1'b1;
              cmd.vout_sel = VOUT_RDATA;
            end
            default: ;
          endcase
        end else if (state_r == S_SCAN_RD) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_UP_RD: begin
        if (stat.at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_VALUE;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
        end
      end
      S_UP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MOVE;
        cmd.idx_dec = 1'b1;
      end
      S_DN_RD: begin
        if (stat.last) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MOVE;
        cmd.idx_inc = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !stat.out_stall;
      end
      default: ;
    endcase
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DECODE))
    else $error("accepted request did not start decode");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_stall)
    else $error("result loaded over a stalled result");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en))
    else $error("read and write issued in the same cycle");

endmodule

// ===== hdl/sle_dp.sv =====
// Datapath: list storage, scan index, entry count, compare and result registers.
module sle_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sle_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [sle_pkg::DATA_W-1:0] in_value,
  input  logic                             out_ready,
  input  sle_pkg::sle_cmd_t                cmd,
  output sle_pkg::sle_stat_t               stat,
  output logic                             out_valid,
  output logic [sle_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_found,
  output logic signed [sle_pkg::DATA_W-1:0] out_value,
  output logic [sle_pkg::POS_W-1:0]        out_position,
  output logic [sle_pkg::COUNT_W-1:0]      out_count
);
  import sle_pkg::*;

  logic [MODE_W-1:0]        mode_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         idx_r;
  logic [IDX_W-1:0]         pos_r;
  logic [STATUS_W-1:0]      status_r;
  logic                     found_r;
  logic signed [DATA_W-1:0] vout_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_found_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [POS_W-1:0]         out_position_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic [CNT_W-1:0]  idx_prev;
  logic [CNT_W-1:0]  idx_next;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;

  assign idx_prev = idx_r - CNT_W'(1);
  assign idx_next = idx_r + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_addr = idx_prev[IDX_W-1:0];
      RD_NEXT: rd_addr = idx_next[IDX_W-1:0];
      default: rd_addr = idx_r[IDX_W-1:0];
    endcase
  end

  assign wr_data = (cmd.wr_sel == WR_VALUE) ? val_r : rd_data;

  sle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (idx_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.mode      = mode_r;
    stat.full      = (cnt_r == CNT_W'(DEPTH));
    stat.empty     = (cnt_r == '0);
    stat.at_end    = (idx_r == cnt_r);
    stat.at_pos    = (idx_r == CNT_W'(pos_r));
    stat.last      = (idx_next >= cnt_r);
    stat.gt        = ($signed(rd_data) > val_r);
    stat.eq        = (rd_data == val_r);
    stat.out_stall = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      val_r    <= in_value;
      idx_r    <= '0;
      pos_r    <= '0;
      status_r <= ST_OK;
      found_r  <= 1'b0;
      vout_r   <= '0;
    end else begin
      if (cmd.idx_to_cnt) begin
        idx_r <= cnt_r;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_next;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_prev;
      end
      if (cmd.set_pos) begin
        pos_r <= idx_r[IDX_W-1:0];
      end
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.set_found) begin
        found_r <= 1'b1;
      end
      case (cmd.vout_sel)
        VOUT_VALUE: vout_r <= val_r;
        VOUT_RDATA: vout_r <= $signed(rd_data);
        default:    ;
      endcase
    end
  end

  // Output register: hold a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= status_r;
      out_found_r    <= found_r;
      out_value_r    <= vout_r;
      out_position_r <= POS_W'(pos_r);
      out_count_r    <= COUNT_W'(cnt_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_value    = out_value_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (cnt_r != CNT_W'(DEPTH)))
    else $error("insert into a full list");

  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> ((idx_r < CNT_W'(DEPTH)) && (idx_r <= cnt_r)))
    else $error("write outside the occupied range");

endmodule

// ===== hdl/sorted_list_engine.sv =====
// A transferred request is decoded; clear, insert to a full list, pop from an empty list and
// unused codes finish there. Otherwise entries are compared in order up to the first one that
// settles the request or the list end; insert then shifts later entries up, delete and pop down.
// One request at a time: a new request is taken only after the last result is loaded.
// rst_n (synchronous, active low) empties the list and drops any pending result.
// Storage is not cleared; only occupied slots are ever read, so no clearing pass.
module sorted_list_engine (
  input logic      clk,
  input logic      rst_n,
  sle_req_if.sink  in_req,
  sle_rsp_if.source out_rsp
);
  import sle_pkg::*;

  sle_cmd_t  cmd;
  sle_stat_t stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sle_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_req.mode),
    .in_value     (in_req.value),
    .out_ready    (out_rsp.ready),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_rsp.valid),
    .out_status   (out_rsp.status),
    .out_found    (out_rsp.found),
    .out_value    (out_rsp.value_out),
    .out_position (out_rsp.position),
    .out_count    (out_rsp.count)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted list engine: random traffic checked against a list predictor.
`timescale 1ns / 100ps

module testbench;
  import sle_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  localparam int SEG_FILL  = 0;
  localparam int SEG_MIXED = 1;
  localparam int SEG_DRAIN = 2;

  localparam int POOL_N      = 16;
  localparam int PHASE_ITEMS = 330;
  localparam int TAIL_CYCLES = 4 * DEPTH + 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int REPORT_MAX  = 10;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       count;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  sle_req_if in_req();
  sle_rsp_if out_rsp();

  sorted_list_engine uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // predictor state: sorted copy of the list
  logic signed [DATA_W-1:0] list_vals [DEPTH];
  int                       list_len = 0;

  list_req_t request_q [$];
  list_rsp_t rsp_due_q [$];
  list_req_t drive_req;
  list_rsp_t got_rsp;
  list_rsp_t due_rsp;

  logic signed [DATA_W-1:0] value_pool [POOL_N];

  int issued_n       = 0;
  int accepted_n     = 0;
  int mismatch_n     = 0;
  int cycle_n        = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_entry(input logic signed [DATA_W-1:0] v);
    for (int i = 0; i < list_len; i++) begin
      if (list_vals[i] == v) return i;
    end
    return list_len;
  endfunction

  // place after all entries <= v
  function automatic int insert_entry(input logic signed [DATA_W-1:0] v);
    int pos;
    pos = 0;
    while (pos < list_len && list_vals[pos] <= v) pos++;
    for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = v;
    list_len++;
    return pos;
  endfunction

  function automatic void remove_entry(input int pos);
    for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
  endfunction

  function automatic list_rsp_t apply_list_op(input logic [MODE_W-1:0] op,
                                              input logic signed [DATA_W-1:0] v);
    list_rsp_t r;
    int        hit;
    int        pos;
    r = '0;
    hit = find_entry(v);
    case (op)
      MODE_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = insert_entry(v);
          r.position  = pos[POS_W-1:0];
          r.value_out = v;
        end
      end
      MODE_INSERT_ABSENT: begin
        if (hit < list_len) begin
          r.found     = 1'b1;
          r.value_out = v;
          r.position  = hit[POS_W-1:0];
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = insert_entry(v);
          r.position  = pos[POS_W-1:0];
          r.value_out = v;
        end
      end
      MODE_SEARCH, MODE_DELETE: begin
        if (hit < list_len) begin
          r.found     = 1'b1;
          r.value_out = v;
          r.position  = hit[POS_W-1:0];
          if (op == MODE_DELETE) remove_entry(hit);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      MODE_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = list_vals[0];
          remove_entry(0);
        end
      end
      MODE_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 50) return value_pool[$urandom_range(POOL_N-1, 0)];
    if (sel < 62) begin
      case ($urandom_range(4, 0))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return 32'sd0;
        3:       return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  // small values give duplicates and search hits, the rest spread wide
  task automatic refresh_pool();
    for (int i = 0; i < POOL_N; i++) begin
      if (i < 8) value_pool[i] = int'($urandom_range(16, 0)) - 8;
      else if (i == 8) value_pool[i] = VAL_MIN;
      else if (i == 9) value_pool[i] = VAL_MAX;
      else value_pool[i] = $urandom();
    end
  endtask

  task automatic push_req(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
    list_req_t req;
    req.mode  = m;
    req.value = v;
    request_q.push_back(req);
  endtask

  task automatic add_random_ops(input int n, input int seg);
    int               r;
    logic [MODE_W-1:0] m;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99, 0);
      case (seg)
        SEG_FILL: begin
          if (r < 70) m = MODE_INSERT;
          else if (r < 90) m = MODE_INSERT_ABSENT;
          else m = MODE_SEARCH;
        end
        SEG_MIXED: begin
          if (r < 22) m = MODE_INSERT;
          else if (r < 37) m = MODE_INSERT_ABSENT;
          else if (r < 57) m = MODE_SEARCH;
          else if (r < 77) m = MODE_DELETE;
          else if (r < 90) m = MODE_POP;
          else if (r < 93) m = MODE_CLEAR;
          else if (r < 96) m = MODE_UNUSED_6;
          else m = MODE_UNUSED_7;
        end
        default: begin
          if (r < 45) m = MODE_POP;
          else if (r < 85) m = MODE_DELETE;
          else if (r < 95) m = MODE_SEARCH;
          else m = MODE_INSERT;
        end
      endcase
      if (m == MODE_POP || m == MODE_CLEAR || m == MODE_UNUSED_6 || m == MODE_UNUSED_7)
        push_req(m, $urandom());
      else
        push_req(m, pick_value());
    end
  endtask

  // hold off until every issued request has its result back
  task automatic wait_drained();
    while (request_q.size() != 0 || accepted_n != issued_n || rsp_due_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int seg;
    int len;
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
    refresh_pool();
    // start from a full list so the full cases come up early
    push_req(MODE_CLEAR, $urandom());
    for (int k = 0; k < DEPTH; k++) push_req(MODE_INSERT, pick_value());
    add_random_ops(6, SEG_FILL);
    sent = DEPTH + 7;
    while (sent < n_items) begin
      seg = $urandom_range(2, 0);
      if (seg == SEG_FILL) len = $urandom_range(72, 8);
      else if (seg == SEG_MIXED) len = $urandom_range(40, 20);
      else len = $urandom_range(60, 10);
      add_random_ops(len, seg);
      sent += len;
    end
    wait_drained();
  endtask

  // driver: present the next item on the falling edge, hold until transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || accepted_n == issued_n) begin
      if (request_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        drive_req = request_q.pop_front();
        in_req.valid <= 1'b1;
        in_req.mode  <= drive_req.mode;
        in_req.value <= drive_req.value;
        issued_n++;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
    out_rsp.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // monitor: check results first, then predict for the request transferred at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready) begin
        got_rsp.status    = out_rsp.status;
        got_rsp.found     = out_rsp.found;
        got_rsp.value_out = out_rsp.value_out;
        got_rsp.position  = out_rsp.position;
        got_rsp.count     = out_rsp.count;
        if (rsp_due_q.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= REPORT_MAX)
            $display("%0t: result with none pending: status %0d found %0b value %0d pos %0d count %0d",
                     $realtime, got_rsp.status, got_rsp.found, got_rsp.value_out,
                     got_rsp.position, got_rsp.count);
        end else begin
          due_rsp = rsp_due_q.pop_front();
          if (got_rsp !== due_rsp) begin
            mismatch_n++;
            if (mismatch_n <= REPORT_MAX)
              $display("%0t: mismatch: exp status %0d found %0b value %0d pos %0d count %0d / got status %0d found %0b value %0d pos %0d count %0d",
                       $realtime, due_rsp.status, due_rsp.found, due_rsp.value_out,
                       due_rsp.position, due_rsp.count, got_rsp.status, got_rsp.found,
                       got_rsp.value_out, got_rsp.position, got_rsp.count);
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        rsp_due_q.push_back(apply_list_op(in_req.mode, in_req.value));
        accepted_n++;
      end
    end
  end

  initial begin
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_req.valid  = 1'b0;
    in_req.mode   = MODE_INSERT;
    in_req.value  = '0;
    out_rsp.ready = 1'b0;
    refresh_pool();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, extremes, duplicates, hits and misses, unused codes
    push_req(MODE_POP, 32'sd0);
    push_req(MODE_SEARCH, 32'sd0);
    push_req(MODE_DELETE, 32'sd5);
    push_req(MODE_UNUSED_6, VAL_MAX);
    push_req(MODE_INSERT_ABSENT, 32'sd7);
    push_req(MODE_INSERT, VAL_MAX);
    push_req(MODE_INSERT, VAL_MIN);
    push_req(MODE_INSERT, 32'sd0);
    push_req(MODE_INSERT, 32'sd0);
    push_req(MODE_INSERT, -32'sd1);
    push_req(MODE_INSERT, 32'sd1);
    push_req(MODE_SEARCH, VAL_MIN);
    push_req(MODE_SEARCH, VAL_MAX);
    push_req(MODE_SEARCH, 32'sd3);
    push_req(MODE_INSERT_ABSENT, 32'sd0);
    push_req(MODE_DELETE, 32'sd0);
    push_req(MODE_DELETE, 32'sd99);
    push_req(MODE_DELETE, VAL_MAX);
    push_req(MODE_POP, -32'sd1);
    push_req(MODE_UNUSED_7, -32'sd1);
    push_req(MODE_CLEAR, VAL_MIN);
    push_req(MODE_POP, VAL_MAX);
    push_req(MODE_INSERT_ABSENT, VAL_MIN);
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(87, 0, PHASE_ITEMS);
    run_phase(0, 87, PHASE_ITEMS);
    run_phase(20, 20, PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_n == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
